FILE: hdl/lssp_pkg.sv
// ----------------------------------------------------------------------------
// LED strip status pattern package
// Shared constants and types of the status pattern generator.
// ----------------------------------------------------------------------------
package lssp_pkg;

    localparam int PIXEL_COUNT = 8;
    localparam int PIX_N = (PIXEL_COUNT < 1) ? 1 : ((PIXEL_COUNT > 64) ? 64 : PIXEL_COUNT);

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_BLUE    = 3'd1,
        MODE_RED     = 3'd2,
        MODE_GREEN   = 3'd3,
        MODE_AMBER   = 3'd4,
        MODE_RAINBOW = 3'd5,
        MODE_MINT    = 3'd6,
        MODE_NONE    = 3'd7
    } t_mode;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_FLOOR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLINK,
        ST_CALC,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       start;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] add;
        logic       round;
    } t_mul_req;

endpackage

FILE: hdl/lssp_mul.sv
// ----------------------------------------------------------------------------
// LED strip multiply-divide unit
// Bit-serial (a*b + add + round*127) / 255 on 8-bit operands.
// ----------------------------------------------------------------------------
module lssp_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lssp_pkg::t_mul_req i_req,
    output logic              o_done,
    output logic [7:0]        o_q
);
    logic [16:0] r_acc, n_acc;
    logic [7:0]  r_b, n_b;
    logic [16:0] r_sh, n_sh;
    logic [4:0]  r_cnt, n_cnt;
    logic [7:0]  r_q, n_q;
    logic        r_busy, n_busy;
    logic [16:0] trial;

    // multiply one bit per cycle, then restoring divide
    always_comb begin
        n_acc = r_acc; n_b = r_b; n_sh = r_sh; n_cnt = r_cnt; n_q = r_q;
        n_busy = r_busy;
        trial = 17'd0;
        o_done = 1'b0;
        if (i_req.start) begin
            n_acc  = {9'd0, i_req.add} + (i_req.round ? 17'd127 : 17'd0);
            n_b    = i_req.b;
            n_sh   = {9'd0, i_req.a};
            n_cnt  = 5'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_cnt < 5'd8) begin
                if (r_b[0]) n_acc = r_acc + r_sh;
                n_b  = {1'b0, r_b[7:1]};
                n_sh = {r_sh[15:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd7) begin
                    n_sh = {1'b0, 8'd255, 8'd0};
                    n_q  = 8'd0;
                end
            end else begin
                trial = r_acc - r_sh;
                n_q = {r_q[6:0], !trial[16] && (r_acc >= r_sh)};
                if (r_acc >= r_sh) n_acc = trial;
                n_sh = {1'b0, r_sh[16:1]};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    n_busy = 1'b0;
                    o_done = 1'b1;
                end
            end
        end
    end

    assign o_q = n_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        r_b   <= n_b;
        r_sh  <= n_sh;
        r_q   <= n_q;
    end
endmodule

FILE: hdl/led_strip_status_pattern.sv
// ----------------------------------------------------------------------------
// LED strip status pattern generator
// One frame tick in, one RGB result per strip pixel out.
// ----------------------------------------------------------------------------
// channel | direction | handshake               | payload
// cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// tick    | in        | i_valid/o_ready         | i_now_ticks
// pixel   | out       | o_valid/i_ready         | o_pixel_index, o_red, o_green, o_blue, o_last_pixel
// A tick is taken only in idle and is followed by the blink check state.
// A wave pixel takes passes, each an issue state and then the serial
// multiply-divide unit: 6 passes for rainbow and 9 passes for
// mint-purple, then the output load. Other modes emit one pixel a cycle
// while the output is not stalled. Reset restores the state, configuration,
// phase and valid registers. A stalled output holds the pixel and the generator waits.
// ----------------------------------------------------------------------------
module led_strip_status_pattern (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_now_ticks,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_pixel_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_last_pixel
);
    lssp_pkg::t_state r_st, n_st;
    lssp_pkg::t_mode  r_mode;
    logic [15:0] r_period;
    logic [7:0]  r_floor, r_phase;
    logic [31:0] r_last_t, r_now;
    logic        r_lit;
    logic [5:0]  r_pix;
    logic [3:0]  r_step, n_step;
    logic [7:0]  r_ts, r_mix, r_inten, r_r, r_g, r_b;
    logic [7:0]  r_ro, r_go, r_bo;
    logic [5:0]  r_po;
    logic        r_lo, r_ov;
    logic        wave;
    logic [7:0]  hue, wph, tri_in, tri_t;
    logic [7:0]  wp, rr, gg, bb;
    lssp_pkg::t_mul_req req;
    logic        done;
    logic [7:0]  q;
    logic        last;
    logic        load;

    lssp_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .o_done(done), .o_q(q));

    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_st == lssp_pkg::ST_IDLE);
    assign wave = (r_mode == lssp_pkg::MODE_RAINBOW) || (r_mode == lssp_pkg::MODE_MINT);
    assign hue = 8'(r_pix * 3) + r_phase;
    assign wph = 8'(r_pix * 5) - {r_phase[6:0], 1'b0};
    assign last = (r_pix == 6'(lssp_pkg::PIX_N - 1));
    assign tri_in = (r_step == 4'd0) ? wph : hue;
    assign tri_t = tri_in[7] ? (8'd255 - {tri_in[6:0], 1'b0}) : {tri_in[6:0], 1'b0};
    assign wp = 8'd255 - hue;
    assign load = (r_st == lssp_pkg::ST_OUT) && (!r_ov || i_ready);

    // wheel color, compare against segment bounds
    always_comb begin
        rr = 8'd0; gg = 8'd0; bb = 8'd0;
        if (wp < 8'd85) begin
            rr = 8'(255 - 3 * wp); bb = 8'(3 * wp);
        end else if (wp < 8'd170) begin
            gg = 8'(3 * (wp - 8'd85)); bb = 8'(255 - 3 * (wp - 8'd85));
        end else begin
            rr = 8'(3 * (wp - 8'd170)); gg = 8'(255 - 3 * (wp - 8'd170));
        end
    end

    // steps: 0 tri(wph) 1 lift 2 tri(hue) 3..5 mix r/g/b 6..8 scale r/g/b
    always_comb begin
        n_st = r_st;
        n_step = r_step;
        unique case (r_st)
            lssp_pkg::ST_IDLE: if (i_valid) n_st = lssp_pkg::ST_BLINK;
            lssp_pkg::ST_BLINK: begin
                n_st = wave ? lssp_pkg::ST_CALC : lssp_pkg::ST_OUT;
                n_step = 4'd0;
            end
            lssp_pkg::ST_CALC: n_st = lssp_pkg::ST_MUL;
            lssp_pkg::ST_MUL: if (done) begin
                n_st = lssp_pkg::ST_CALC;
                n_step = r_step + 4'd1;
                if (r_step == 4'd2 && r_mode == lssp_pkg::MODE_RAINBOW) n_step = 4'd6;
                if (r_step == 4'd8) n_st = lssp_pkg::ST_OUT;
            end
            lssp_pkg::ST_OUT: if (!r_ov || i_ready) begin
                n_step = 4'd0;
                n_st = last ? lssp_pkg::ST_IDLE : (wave ? lssp_pkg::ST_CALC : lssp_pkg::ST_OUT);
            end
            default: n_st = lssp_pkg::ST_IDLE;
        endcase
    end

    // mix terms: 70 - ceil(10*mix/255), 20 + 200*mix/255, 130 + 70*mix/255
    always_comb begin
        req = '0;
        if (r_st == lssp_pkg::ST_CALC) begin
            req.start = 1'b1;
            unique case (r_step)
                4'd0, 4'd2: begin req.a = tri_t; req.b = tri_t; end
                4'd1: begin req.a = r_ts; req.b = 8'd255 - r_floor; req.round = 1'b1; end
                4'd3: begin req.a = 8'd10; req.b = r_mix; req.add = 8'd254; end
                4'd4: begin req.a = 8'd200; req.b = r_mix; end
                4'd5: begin req.a = 8'd70; req.b = r_mix; end
                4'd6: begin req.a = r_r; req.b = r_inten; req.round = 1'b1; end
                4'd7: begin req.a = r_g; req.b = r_inten; req.round = 1'b1; end
                default: begin req.a = r_b; req.b = r_inten; req.round = 1'b1; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= lssp_pkg::ST_IDLE;
            r_mode <= lssp_pkg::MODE_RAINBOW;
            r_period <= 16'd400;
            r_floor <= 8'd35;
            r_phase <= 8'd0;
            r_last_t <= 32'd0;
            r_lit <= 1'b0;
            r_ov <= 1'b0;
            r_step <= 4'd0;
            r_pix <= 6'd0;
        end else begin
            r_st <= n_st;
            r_step <= n_step;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lssp_pkg::REG_MODE:   r_mode <= lssp_pkg::t_mode'(i_cfg_data[2:0]);
                    lssp_pkg::REG_PERIOD: r_period <= i_cfg_data;
                    lssp_pkg::REG_FLOOR:  r_floor <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_st == lssp_pkg::ST_IDLE && i_valid) begin
                r_now <= i_now_ticks;
                r_pix <= 6'd0;
            end
            if (r_st == lssp_pkg::ST_BLINK &&
                (r_mode == lssp_pkg::MODE_GREEN || r_mode == lssp_pkg::MODE_AMBER) &&
                (r_now - r_last_t) >= {16'd0, r_period}) begin
                r_last_t <= r_now;
                r_lit <= !r_lit;
            end
            if (r_st == lssp_pkg::ST_MUL && done) begin
                unique case (r_step)
                    4'd0: r_ts <= q;
                    4'd1: r_inten <= q + r_floor;
                    4'd2: begin
                        r_mix <= q;
                        if (r_mode == lssp_pkg::MODE_RAINBOW) begin
                            r_r <= rr; r_g <= gg; r_b <= bb;
                        end
                    end
                    4'd3: r_r <= 8'd70 - q;
                    4'd4: r_g <= 8'd20 + q;
                    4'd5: r_b <= 8'd130 + q;
                    4'd6: r_r <= q;
                    4'd7: r_g <= q;
                    4'd8: r_b <= q;
                    default: ;
                endcase
            end
            if (load) begin
                r_ov <= 1'b1;
                r_po <= r_pix;
                r_lo <= last;
                if (wave) begin
                    r_ro <= r_r; r_go <= r_g; r_bo <= r_b;
                end else begin
                    r_ro <= (r_mode == lssp_pkg::MODE_RED ||
                             (r_mode == lssp_pkg::MODE_AMBER && r_lit)) ? 8'd255 : 8'd0;
                    r_go <= (r_mode == lssp_pkg::MODE_GREEN && r_lit) ? 8'd255 :
                            ((r_mode == lssp_pkg::MODE_AMBER && r_lit) ? 8'd120 : 8'd0);
                    r_bo <= (r_mode == lssp_pkg::MODE_BLUE) ? 8'd255 : 8'd0;
                end
                r_pix <= r_pix + 6'd1;
                if (last && wave) r_phase <= r_phase + 8'd1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_pixel_index = r_po;
    assign o_red = r_ro;
    assign o_green = r_go;
    assign o_blue = r_bo;
    assign o_last_pixel = r_lo;
endmodule
